// ----- rtl/core/dtdn_pkg.sv -----
// Shared types, status codes and the month offset table for the date converter.
`timescale 1ns / 1ps
package dtdn_pkg;

    localparam int CHAR_W = 8;
    localparam int NUM_W  = 22;
    localparam int SPAN_W = 23;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_NODIGIT  = 3'd2,
        ST_BADDAY   = 3'd3,
        ST_BADMONTH = 3'd4,
        ST_BADFEB   = 3'd5
    } status_t;

    typedef struct packed {
        logic [CHAR_W-1:0] day_tens;
        logic [CHAR_W-1:0] day_ones;
        logic [CHAR_W-1:0] month_tens;
        logic [CHAR_W-1:0] month_ones;
        logic [CHAR_W-1:0] year_thousands;
        logic [CHAR_W-1:0] year_hundreds;
        logic [CHAR_W-1:0] year_tens;
        logic [CHAR_W-1:0] year_ones;
    } date_chars_t;

    typedef struct packed {
        status_t           status;
        logic [NUM_W-1:0]  day_number;
    } conv_res_t;

    // Days in the year before the first of month m (January = 1).
    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] r;
        unique case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic digit_ok(input logic [CHAR_W-1:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

endpackage

// ----- rtl/core/dtdn_if.sv -----
// Valid/ready channel interfaces for date items and conversion results.
`timescale 1ns / 1ps
interface dtdn_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] day_tens;
    logic [7:0] day_ones;
    logic [7:0] month_tens;
    logic [7:0] month_ones;
    logic [7:0] year_thousands;
    logic [7:0] year_hundreds;
    logic [7:0] year_tens;
    logic [7:0] year_ones;
    logic       pair_second;

    modport source (
        output valid, day_tens, day_ones, month_tens, month_ones,
               year_thousands, year_hundreds, year_tens, year_ones, pair_second,
        input  ready
    );
    modport sink (
        input  valid, day_tens, day_ones, month_tens, month_ones,
               year_thousands, year_hundreds, year_tens, year_ones, pair_second,
        output ready
    );
endinterface

interface dtdn_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [21:0]        day_number;
    logic               span_ready;
    logic signed [22:0] span;

    modport source (
        output valid, status, day_number, span_ready, span,
        input  ready
    );
    modport sink (
        input  valid, status, day_number, span_ready, span,
        output ready
    );
endinterface

// ----- rtl/core/dtdn_conv.sv -----
// Date check and conversion of DD MM YYYY digit characters to a serial day number.
`timescale 1ns / 1ps
module dtdn_conv
    import dtdn_pkg::*;
(
    input  date_chars_t chars,
    output conv_res_t   res
);

    logic [6:0]       day;
    logic [6:0]       month;
    logic [6:0]       cen;
    logic [6:0]       yy;
    logic [13:0]      year;
    logic [13:0]      e;
    logic [6:0]       e_div100;
    logic [4:0]       e_div400;
    logic [11:0]      e_div4;
    logic             leap;
    logic             feb_bad;
    logic [NUM_W-1:0] base;
    logic [NUM_W-1:0] num_long;
    logic [NUM_W-1:0] num_short;

    assign day   = 7'(chars.day_tens[3:0]) * 7'd10 + 7'(chars.day_ones[3:0]);
    assign month = 7'(chars.month_tens[3:0]) * 7'd10 + 7'(chars.month_ones[3:0]);
    assign cen   = 7'(chars.year_thousands[3:0]) * 7'd10 + 7'(chars.year_hundreds[3:0]);
    assign yy    = 7'(chars.year_tens[3:0]) * 7'd10 + 7'(chars.year_ones[3:0]);
    assign year  = 14'(cen) * 14'd100 + 14'(yy);

    // Divisibility by 4, 100 and 400 read straight off the digit pairs
    assign leap = (yy[1:0] == 2'd0) && ((yy != 7'd0) || (cen[1:0] == 2'd0));

    // Quotients of year-1; only used for years above 1
    assign e        = year - 14'd1;
    assign e_div4   = e[13:2];
    assign e_div100 = (yy == 7'd0) ? cen - 7'd1 : cen;
    assign e_div400 = e_div100[6:2];

    assign feb_bad = (month == 7'd2) && (day > (leap ? 7'd29 : 7'd28));

    // Years 0 and 1 get no leap-day offset in the day number, so it only goes into the long form
    assign base = 22'(day) + 22'(days_before(month[3:0]));
    assign num_long = base + 22'(leap && (month > 7'd2)) + 22'(e) * 22'd365
                    + 22'(e_div4) - 22'(e_div100) + 22'(e_div400);
    assign num_short = base + ((year == 14'd1) ? 22'd365 : 22'd0);

    always_comb
    begin
        res.status     = ST_OK;
        res.day_number = '0;
        priority if (chars.day_tens == 8'h00)
        begin
            res.status = ST_EMPTY;
        end
        else if (!digit_ok(chars.day_tens) || !digit_ok(chars.day_ones))
        begin
            res.status = ST_NODIGIT;
        end
        else if ((day < 7'd1) || (day > 7'd31))
        begin
            res.status = ST_BADDAY;
        end
        else if (!digit_ok(chars.month_tens) || !digit_ok(chars.month_ones))
        begin
            res.status = ST_NODIGIT;
        end
        else if ((month < 7'd1) || (month > 7'd12))
        begin
            res.status = ST_BADMONTH;
        end
        else if (!digit_ok(chars.year_thousands) || !digit_ok(chars.year_hundreds) ||
                 !digit_ok(chars.year_tens) || !digit_ok(chars.year_ones))
        begin
            res.status = ST_NODIGIT;
        end
        else if (feb_bad)
        begin
            res.status = ST_BADFEB;
        end
        else
        begin
            res.day_number = (year > 14'd1) ? num_long : num_short;
        end
    end

endmodule

// ----- rtl/core/dtdn_span.sv -----
// Inclusive span between the stored first date and the current one.
`timescale 1ns / 1ps
module dtdn_span
    import dtdn_pkg::*;
(
    input  logic [NUM_W-1:0]         first_num,
    input  logic                     first_ok,
    input  conv_res_t                cur,
    output logic signed [SPAN_W-1:0] span
);

    logic [NUM_W-1:0] diff;

    assign diff = (first_num > cur.day_number) ? first_num - cur.day_number
                                               : cur.day_number - first_num;

    assign span = (first_ok && (cur.status == ST_OK))
                ? $signed(SPAN_W'(diff) + SPAN_W'(1))
                : $signed({SPAN_W{1'b1}});

endmodule

// ----- rtl/core/date_to_day_number_span.sv -----
// Top level: date to day number converter with pairwise span, input and result registers.
//
//   channel | dir | payload
//   din     | in  | eight ASCII date characters, pair_second
//   dout    | out | status, day_number, span_ready, span
//
// One transaction per cycle sustained while dout is ready.
// Conversion and span sit between the input register and the result register.
// The stored first date updates as a first-of-pair item moves into the result register.
// A stall on dout holds the result register and then the input register;
// din is refused only when both are full. Reset clears valids and the first date.
`timescale 1ns / 1ps
module date_to_day_number_span
    import dtdn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    dtdn_in_if.sink     din,
    dtdn_out_if.source  dout
);

    logic                     in_valid_reg, in_valid_next;
    date_chars_t              chars_reg;
    logic                     second_reg;
    logic                     out_valid_reg, out_valid_next;
    logic [2:0]               status_reg;
    logic [NUM_W-1:0]         num_reg;
    logic                     span_ready_reg;
    logic signed [SPAN_W-1:0] span_reg;
    logic [NUM_W-1:0]         first_num_reg, first_num_next;
    logic                     first_ok_reg, first_ok_next;

    logic                     din_acc;
    logic                     adv;
    conv_res_t                conv;
    logic signed [SPAN_W-1:0] span_calc;

    dtdn_conv u_conv (
        .chars (chars_reg),
        .res   (conv)
    );

    dtdn_span u_span (
        .first_num (first_num_reg),
        .first_ok  (first_ok_reg),
        .cur       (conv),
        .span      (span_calc)
    );

    assign adv       = in_valid_reg && (!out_valid_reg || dout.ready);
    assign din.ready = !in_valid_reg || adv;
    assign din_acc   = din.valid && din.ready;

    always_comb
    begin
        in_valid_next  = din_acc ? 1'b1 : (adv ? 1'b0 : in_valid_reg);
        out_valid_next = adv ? 1'b1 : (dout.ready ? 1'b0 : out_valid_reg);
        first_num_next = first_num_reg;
        first_ok_next  = first_ok_reg;
        if (adv && !second_reg)
        begin
            first_num_next = conv.day_number;
            first_ok_next  = (conv.status == ST_OK);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            first_num_reg <= '0;
            first_ok_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            first_num_reg <= first_num_next;
            first_ok_reg  <= first_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (din_acc)
        begin
            chars_reg.day_tens       <= din.day_tens;
            chars_reg.day_ones       <= din.day_ones;
            chars_reg.month_tens     <= din.month_tens;
            chars_reg.month_ones     <= din.month_ones;
            chars_reg.year_thousands <= din.year_thousands;
            chars_reg.year_hundreds  <= din.year_hundreds;
            chars_reg.year_tens      <= din.year_tens;
            chars_reg.year_ones      <= din.year_ones;
            second_reg               <= din.pair_second;
        end
        if (adv)
        begin
            status_reg     <= conv.status;
            num_reg        <= conv.day_number;
            span_ready_reg <= second_reg;
            span_reg       <= second_reg ? span_calc : '0;
        end
    end

    assign dout.valid      = out_valid_reg;
    assign dout.status     = status_reg;
    assign dout.day_number = num_reg;
    assign dout.span_ready = span_ready_reg;
    assign dout.span       = span_reg;

endmodule

// ----- dv/tb_top.sv -----
// Self-checking bench for the date to day number converter with pairwise span.
`timescale 1ns / 1ps
module tb_top;
    import dtdn_pkg::*;

    typedef struct {
        date_chars_t chars;
        logic        second;
    } date_item_t;

    typedef struct {
        status_t            status;
        logic [NUM_W-1:0]   day_number;
        logic               span_ready;
        logic signed [22:0] span;
    } day_result_t;

    typedef enum logic [1:0] {
        RX_FLOW,
        RX_RANDOM,
        RX_PATTERN
    } rx_mode_t;

    localparam int LONG_HOLD   = 80;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 650;
    localparam int CHUNKS       = 4;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    dtdn_in_if  din_ch ();
    dtdn_out_if dout_ch ();

    date_to_day_number_span dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_ch),
        .dout  (dout_ch)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    date_item_t  pending_dates[$];
    day_result_t awaited_results[$];

    // stored first date of the current pair
    logic [NUM_W-1:0] first_number = '0;
    logic             first_good = 1'b0;

    int errors = 0;
    int dates_in = 0;
    int results_out = 0;
    int good_dates = 0;
    int spans_seen = 0;
    int stall_cycles = 0;
    int hold_requests = 0;
    int holds_done = 0;

    function automatic bit is_numeral(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic bit leap_year(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic void convert_date(input date_chars_t c, output status_t st,
                                         output logic [NUM_W-1:0] num);
        int unsigned d;
        int unsigned m;
        int unsigned y;
        int unsigned e;
        int unsigned total;
        int unsigned month_start [13] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243,
                                          273, 304, 334};
        num = '0;
        st = ST_OK;
        if (c.day_tens == 8'h00)
        begin
            st = ST_EMPTY;
            return;
        end
        if (!is_numeral(c.day_tens) || !is_numeral(c.day_ones))
        begin
            st = ST_NODIGIT;
            return;
        end
        d = (c.day_tens - 8'h30) * 10 + (c.day_ones - 8'h30);
        if (d < 1 || d > 31)
        begin
            st = ST_BADDAY;
            return;
        end
        if (!is_numeral(c.month_tens) || !is_numeral(c.month_ones))
        begin
            st = ST_NODIGIT;
            return;
        end
        m = (c.month_tens - 8'h30) * 10 + (c.month_ones - 8'h30);
        if (m < 1 || m > 12)
        begin
            st = ST_BADMONTH;
            return;
        end
        if (!is_numeral(c.year_thousands) || !is_numeral(c.year_hundreds) ||
            !is_numeral(c.year_tens) || !is_numeral(c.year_ones))
        begin
            st = ST_NODIGIT;
            return;
        end
        y = (c.year_thousands - 8'h30) * 1000 + (c.year_hundreds - 8'h30) * 100
            + (c.year_tens - 8'h30) * 10 + (c.year_ones - 8'h30);
        if (m == 2 && d > (leap_year(y) ? 29 : 28))
        begin
            st = ST_BADFEB;
            return;
        end
        if (y > 1)
        begin
            e = y - 1;
            total = d + month_start[m] + ((leap_year(y) && m > 2) ? 1 : 0)
                    + e * 365 + e / 4 - e / 100 + e / 400;
        end
        else
        begin
            total = d + month_start[m] + y * 365;
        end
        num = total[NUM_W-1:0];
    endfunction

    // Works out the result of one accepted date and advances the pair state.
    function automatic day_result_t predict_day(input date_item_t it);
        day_result_t r;
        status_t st;
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] diff;
        convert_date(it.chars, st, num);
        r.status = st;
        r.day_number = num;
        r.span_ready = 1'b0;
        r.span = '0;
        if (!it.second)
        begin
            first_number = num;
            first_good = (st == ST_OK);
        end
        else
        begin
            r.span_ready = 1'b1;
            if (first_good && st == ST_OK)
            begin
                diff = (first_number > num) ? first_number - num : num - first_number;
                r.span = $signed({1'b0, diff}) + 23'sd1;
            end
            else
            begin
                r.span = -23'sd1;
            end
        end
        return r;
    endfunction

    function automatic date_chars_t text_chars(input string s);
        date_chars_t c;
        c.day_tens       = s[0];
        c.day_ones       = s[1];
        c.month_tens     = s[2];
        c.month_ones     = s[3];
        c.year_thousands = s[4];
        c.year_hundreds  = s[5];
        c.year_tens      = s[6];
        c.year_ones      = s[7];
        return c;
    endfunction

    task automatic add_date(input date_chars_t c, input bit second);
        date_item_t it;
        it.chars = c;
        it.second = second;
        pending_dates.push_back(it);
    endtask

    function automatic date_chars_t random_date(input bit noisy);
        date_chars_t c;
        int unsigned d;
        int unsigned m;
        int unsigned y;
        d = $urandom_range(1, 31);
        m = $urandom_range(1, 12);
        if ($urandom_range(0, 5) == 0)
        begin
            // February near its end
            m = 2;
            d = $urandom_range(27, 31);
        end
        case ($urandom_range(0, 9))
            0: y = $urandom_range(0, 3);
            1: y = $urandom_range(0, 99) * 100;
            2: y = $urandom_range(0, 1) ? 9999 : 9996;
            default: y = $urandom_range(0, 9999);
        endcase
        if (noisy)
        begin
            if ($urandom_range(0, 1))
                d = $urandom_range(0, 99);
            else
                m = $urandom_range(0, 99);
        end
        c.day_tens       = 8'(8'h30 + d / 10);
        c.day_ones       = 8'(8'h30 + d % 10);
        c.month_tens     = 8'(8'h30 + m / 10);
        c.month_ones     = 8'(8'h30 + m % 10);
        c.year_thousands = 8'(8'h30 + y / 1000);
        c.year_hundreds  = 8'(8'h30 + (y / 100) % 10);
        c.year_tens      = 8'(8'h30 + (y / 10) % 10);
        c.year_ones      = 8'(8'h30 + y % 10);
        if (noisy)
        begin
            case ($urandom_range(0, 3))
                0: c = {$urandom(), $urandom()};
                1: c[$urandom_range(0, 7) * 8 +: 8] = 8'($urandom_range(0, 255));
                2: c.day_tens = 8'h00;
                default: ;
            endcase
            if ($urandom_range(0, 3) == 0)
                c = {$urandom(), $urandom()};
        end
        return c;
    endfunction

    // ---------------- sender ----------------
    logic din_took = 1'b0;
    int burst_left = 1;
    int gap_left = 0;
    date_item_t next_date;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            din_ch.valid          <= 1'b0;
            din_ch.day_tens       <= '0;
            din_ch.day_ones       <= '0;
            din_ch.month_tens     <= '0;
            din_ch.month_ones     <= '0;
            din_ch.year_thousands <= '0;
            din_ch.year_hundreds  <= '0;
            din_ch.year_tens      <= '0;
            din_ch.year_ones      <= '0;
            din_ch.pair_second    <= 1'b0;
        end
        else if (din_ch.valid && !din_took)
        begin
            // transaction still on offer
        end
        else if (gap_left > 0)
        begin
            gap_left <= gap_left - 1;
            din_ch.valid <= 1'b0;
        end
        else if (pending_dates.size() != 0)
        begin
            next_date = pending_dates.pop_front();
            din_ch.day_tens       <= next_date.chars.day_tens;
            din_ch.day_ones       <= next_date.chars.day_ones;
            din_ch.month_tens     <= next_date.chars.month_tens;
            din_ch.month_ones     <= next_date.chars.month_ones;
            din_ch.year_thousands <= next_date.chars.year_thousands;
            din_ch.year_hundreds  <= next_date.chars.year_hundreds;
            din_ch.year_tens      <= next_date.chars.year_tens;
            din_ch.year_ones      <= next_date.chars.year_ones;
            din_ch.pair_second    <= next_date.second;
            din_ch.valid <= 1'b1;
            if (burst_left <= 1)
            begin
                burst_left <= $urandom_range(1, 16);
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
            else
            begin
                burst_left <= burst_left - 1;
            end
        end
        else
        begin
            din_ch.valid <= 1'b0;
        end
    end

    // ---------------- receiver ----------------
    rx_mode_t rx_mode = RX_FLOW;
    int rx_left = 0;
    int hold_left = 0;
    int rx_cycle = 0;

    always @(negedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            dout_ch.ready <= 1'b0;
        end
        else if (holds_done != hold_requests)
        begin
            holds_done <= holds_done + 1;
            hold_left <= LONG_HOLD;
            dout_ch.ready <= 1'b0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode <= rx_mode_t'($urandom_range(0, 2));
                rx_left <= $urandom_range(20, 150);
            end
            else
            begin
                rx_left <= rx_left - 1;
            end
            case (rx_mode)
                RX_FLOW:    dout_ch.ready <= 1'b1;
                RX_RANDOM:  dout_ch.ready <= 1'($urandom_range(0, 1));
                RX_PATTERN: dout_ch.ready <= (rx_cycle % 5 != 1) && (rx_cycle % 5 != 2);
                default:    dout_ch.ready <= 1'b1;
            endcase
        end
    end

    // ---------------- prediction, checking, watchdog ----------------
    day_result_t want;
    date_item_t seen_date;

    always @(posedge clk)
    begin
        din_took <= rst_n && din_ch.valid && din_ch.ready;
        if (rst_n)
        begin
            if (din_ch.valid && din_ch.ready)
            begin
                seen_date.chars = {din_ch.day_tens, din_ch.day_ones, din_ch.month_tens,
                                   din_ch.month_ones, din_ch.year_thousands,
                                   din_ch.year_hundreds, din_ch.year_tens,
                                   din_ch.year_ones};
                seen_date.second = din_ch.pair_second;
                awaited_results.push_back(predict_day(seen_date));
                dates_in++;
            end
            if (dout_ch.valid && dout_ch.ready)
            begin
                results_out++;
                if (awaited_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result status=%0d day_number=%0d span=%0d",
                             $time, dout_ch.status, dout_ch.day_number, dout_ch.span);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (want.status == ST_OK)
                        good_dates++;
                    if (want.span_ready)
                        spans_seen++;
                    if (dout_ch.status !== want.status)
                    begin
                        errors++;
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, dout_ch.status);
                    end
                    if (dout_ch.day_number !== want.day_number)
                    begin
                        errors++;
                        $display("%0t: day_number expected %0d got %0d",
                                 $time, want.day_number, dout_ch.day_number);
                    end
                    if (dout_ch.span_ready !== want.span_ready)
                    begin
                        errors++;
                        $display("%0t: span_ready expected %0b got %0b",
                                 $time, want.span_ready, dout_ch.span_ready);
                    end
                    if (dout_ch.span !== want.span)
                    begin
                        errors++;
                        $display("%0t: span expected %0d got %0d",
                                 $time, want.span, dout_ch.span);
                    end
                end
            end
            if ((din_ch.valid && din_ch.ready) || (dout_ch.valid && dout_ch.ready) ||
                (!din_ch.valid && awaited_results.size() == 0))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, stall_cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_dates.size() != 0 || din_ch.valid || awaited_results.size() != 0)
            @(posedge clk);
    endtask

    date_chars_t blank;

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: second of a pair straight after reset sees no valid first date
        add_date(text_chars("15062000"), 1'b1);
        blank = text_chars("01012000");
        blank.day_tens = 8'h00;
        add_date(blank, 1'b0);
        add_date(text_chars("01012000"), 1'b1);
        add_date(text_chars("01010000"), 1'b0);
        add_date(text_chars("31129999"), 1'b1);
        add_date(text_chars("01010001"), 1'b1);
        add_date(text_chars("29022000"), 1'b0);
        add_date(text_chars("29021900"), 1'b1);
        add_date(text_chars("30022024"), 1'b1);
        add_date(text_chars("29022024"), 1'b1);
        add_date(text_chars("29020000"), 1'b1);
        add_date(text_chars("01032024"), 1'b1);
        add_date(text_chars("01031900"), 1'b1);
        add_date(text_chars("31042023"), 1'b1);
        add_date(text_chars("00012000"), 1'b1);
        add_date(text_chars("32012000"), 1'b1);
        add_date(text_chars("15002000"), 1'b1);
        add_date(text_chars("15132000"), 1'b1);
        add_date(text_chars("/1012000"), 1'b0);
        add_date(text_chars("1:012000"), 1'b1);
        add_date(text_chars("15/12000"), 1'b1);
        add_date(text_chars("151:2000"), 1'b1);
        add_date(text_chars("1512/000"), 1'b1);
        add_date(text_chars("15122:0/"), 1'b1);
        add_date(text_chars("0113/000"), 1'b1);
        wait_drained();

        // random: mostly well-formed pairs, some corrupted text
        for (int chunk = 0; chunk < CHUNKS; chunk++)
        begin
            for (int i = 0; i < RANDOM_ITEMS / CHUNKS; i++)
                add_date(random_date($urandom_range(0, 4) == 0), $urandom_range(0, 9) < 5);
            if (chunk == 1 || chunk == 3)
                hold_requests++;
            wait_drained();
        end

        repeat (10) @(posedge clk);
        $display("Run covered %0d dates (%0d valid), %0d results, %0d completed pairs,",
                 dates_in, good_dates, results_out, spans_seen);
        $display("with bursty input, receiver stalls and two long output hold-offs.");
        if (errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("%0d mismatches", errors);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/dtdn_pkg.sv
rtl/core/dtdn_if.sv
rtl/core/dtdn_conv.sv
rtl/core/dtdn_span.sv
rtl/core/date_to_day_number_span.sv
dv/tb_top.sv
